### src/pfsm_pkg.sv
// shared types, constants and functions of the pixel fifo sprite mixer
`default_nettype none

package pfsm_pkg;

    localparam int FIFO_DEPTH  = 8;
    localparam int PLANE_W     = 8;
    localparam int COUNT_W     = 4;
    localparam int DROP_W      = 4;
    localparam int PAL_W       = 8;
    localparam int CODE_W      = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(FIFO_DEPTH);

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_OVERLAY = 2'd1,
        REQ_POP     = 2'd2,
        REQ_DISCARD = 2'd3
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_PAL   = 2'd0,
        CFG_OBJ_PAL0 = 2'd1,
        CFG_OBJ_PAL1 = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                go;
        t_req_type           req_type;
        logic [PLANE_W-1:0]  plane_low;
        logic [PLANE_W-1:0]  plane_high;
        logic                mirror_x;
        logic                palette_select;
        logic                behind_bg;
        logic [DROP_W-1:0]   drop_count;
    } t_fifo_cmd;

    typedef struct packed {
        logic [PAL_W-1:0] bg;
        logic [PAL_W-1:0] obj0;
        logic [PAL_W-1:0] obj1;
    } t_palettes;

    typedef struct packed {
        logic               has_result;
        logic [CODE_W-1:0]  pixel_code;
        logic               underflow;
    } t_fifo_res;

    function automatic logic [PLANE_W-1:0] reverse_byte(input logic [PLANE_W-1:0] v);
        logic [PLANE_W-1:0] b;
        b = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        b = ((b & 8'hCC) >> 2) | ((b & 8'h33) << 2);
        b = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
        return b;
    endfunction

    function automatic logic [1:0] shade_of(input logic [PAL_W-1:0] pal,
                                            input logic [1:0] colour);
        logic [1:0] s;
        unique case (colour)
            2'd0: s = pal[1:0];
            2'd1: s = pal[3:2];
            2'd2: s = pal[5:4];
            2'd3: s = pal[7:6];
            default: s = pal[1:0];
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### src/pfsm_req_if.sv
// request channel of the pixel fifo sprite mixer
`default_nettype none

interface pfsm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] plane_low;
    logic [7:0] plane_high;
    logic       mirror_x;
    logic       palette_select;
    logic       behind_bg;
    logic [3:0] drop_count;

    modport source (
        output valid, req_type, plane_low, plane_high, mirror_x,
               palette_select, behind_bg, drop_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, plane_low, plane_high, mirror_x,
               palette_select, behind_bg, drop_count,
        output ready
    );
endinterface

`default_nettype wire

### src/pfsm_res_if.sv
// result channel of the pixel fifo sprite mixer
`default_nettype none

interface pfsm_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_code;
    logic       underflow;

    modport source (
        output valid, pixel_code, underflow,
        input  ready
    );
    modport sink (
        input  valid, pixel_code, underflow,
        output ready
    );
endinterface

`default_nettype wire

### src/pfsm_fifo.sv
// background and sprite plane registers with pixel mixing
`default_nettype none

module pfsm_fifo import pfsm_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_fifo_cmd  i_cmd,
    input  t_palettes  i_pal,
    output t_fifo_res  o_res
);

    logic [PLANE_W-1:0] r_bg_a, r_bg_b, r_obj_a, r_obj_b, r_obj_pal, r_obj_pri;
    logic [PLANE_W-1:0] n_bg_a, n_bg_b, n_obj_a, n_obj_b, n_obj_pal, n_obj_pri;
    logic [COUNT_W-1:0] r_left, n_left;

    logic [PLANE_W-1:0] spr_lo, spr_hi, mask;
    logic [1:0]         bgc, objc, spr_shade;
    logic               pop_under, drop_under;

    always_comb begin
        spr_lo = i_cmd.mirror_x ? i_cmd.plane_low  : reverse_byte(i_cmd.plane_low);
        spr_hi = i_cmd.mirror_x ? i_cmd.plane_high : reverse_byte(i_cmd.plane_high);
        mask   = (spr_lo | spr_hi) & ~(r_obj_a | r_obj_b);

        bgc        = {r_bg_b[0], r_bg_a[0]};
        objc       = {r_obj_b[0], r_obj_a[0]};
        spr_shade  = shade_of(r_obj_pal[0] ? i_pal.obj1 : i_pal.obj0, objc);
        pop_under  = (r_left == '0);
        drop_under = (i_cmd.drop_count > r_left);

        n_bg_a    = r_bg_a;
        n_bg_b    = r_bg_b;
        n_obj_a   = r_obj_a;
        n_obj_b   = r_obj_b;
        n_obj_pal = r_obj_pal;
        n_obj_pri = r_obj_pri;
        n_left    = r_left;

        o_res = '0;

        unique case (i_cmd.req_type)
            REQ_LOAD: begin
                n_bg_a = reverse_byte(i_cmd.plane_low);
                n_bg_b = reverse_byte(i_cmd.plane_high);
                n_left = COUNT_FULL;
            end
            REQ_OVERLAY: begin
                n_obj_a   = (r_obj_a & ~mask) | (spr_lo & mask);
                n_obj_b   = (r_obj_b & ~mask) | (spr_hi & mask);
                n_obj_pal = (r_obj_pal & ~mask) | (i_cmd.palette_select ? mask : '0);
                n_obj_pri = (r_obj_pri & ~mask) | (i_cmd.behind_bg ? '0 : mask);
            end
            REQ_POP: begin
                n_bg_a    = r_bg_a >> 1;
                n_bg_b    = r_bg_b >> 1;
                n_obj_a   = r_obj_a >> 1;
                n_obj_b   = r_obj_b >> 1;
                n_obj_pal = r_obj_pal >> 1;
                n_obj_pri = r_obj_pri >> 1;
                n_left    = pop_under ? r_left : r_left - COUNT_W'(1);
                o_res.has_result = 1'b1;
                o_res.underflow  = pop_under;
                if (objc != 2'd0 && (r_obj_pri[0] || bgc == 2'd0)) begin
                    o_res.pixel_code = {r_obj_pal[0], ~r_obj_pal[0], spr_shade};
                end else begin
                    o_res.pixel_code = {2'b00, shade_of(i_pal.bg, bgc)};
                end
            end
            REQ_DISCARD: begin
                n_bg_a    = r_bg_a >> i_cmd.drop_count;
                n_bg_b    = r_bg_b >> i_cmd.drop_count;
                n_obj_a   = r_obj_a >> i_cmd.drop_count;
                n_obj_b   = r_obj_b >> i_cmd.drop_count;
                n_obj_pal = r_obj_pal >> i_cmd.drop_count;
                n_obj_pri = r_obj_pri >> i_cmd.drop_count;
                n_left    = drop_under ? '0 : r_left - i_cmd.drop_count;
                o_res.has_result = 1'b1;
                o_res.underflow  = drop_under;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_a    <= '0;
            r_bg_b    <= '0;
            r_obj_a   <= '0;
            r_obj_b   <= '0;
            r_obj_pal <= '0;
            r_obj_pri <= '0;
            r_left    <= '0;
        end else if (i_cmd.go) begin
            r_bg_a    <= n_bg_a;
            r_bg_b    <= n_bg_b;
            r_obj_a   <= n_obj_a;
            r_obj_b   <= n_obj_b;
            r_obj_pal <= n_obj_pal;
            r_obj_pri <= n_obj_pri;
            r_left    <= n_left;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= COUNT_FULL)
        else $error("pixel count above fifo depth");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.go && i_cmd.req_type == REQ_LOAD) |=> (r_left == COUNT_FULL))
        else $error("load did not fill the count");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.go && i_cmd.req_type == REQ_POP && r_left == '0)
        |-> (o_res.underflow ##1 (r_left == '0)))
        else $error("pop on empty fifo not flagged");

    a_overlay_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.go && i_cmd.req_type == REQ_OVERLAY)
        |=> (((r_obj_a | r_obj_b) & ($past(r_obj_a) | $past(r_obj_b)))
             == ($past(r_obj_a) | $past(r_obj_b))))
        else $error("overlay removed a stored sprite pixel");
`endif

endmodule

`default_nettype wire

### src/pixel_fifo_sprite_mixer_top.sv
// top level of the pixel fifo sprite mixer: request register, fifo, result register
//
// channel  dir  handshake       payload
// i_req    in   valid / ready   req_type, plane_low, plane_high, mirror_x,
//                               palette_select, behind_bg, drop_count
// o_res    out  valid / ready   pixel_code, underflow
// i_cfg    in   write enable    i_cfg_idx, i_cfg_data (palettes)
//
// one request per cycle while a stalled result does not hold the request register; a request is
// held in the request register, then the fifo update and pixel mix run together into the result register
// pop and discard give a result through the request and result registers, load and overlay none
// reset is synchronous and clears planes, count, palettes and both valid bits
// a stalled result holds the request register; ready stays high while it can drain
`default_nettype none

module pixel_fifo_sprite_mixer_top import pfsm_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    pfsm_req_if.sink             i_req,
    pfsm_res_if.source           o_res,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [PAL_W-1:0]      i_cfg_data
);

    logic       r_in_valid;
    t_fifo_cmd  r_in;
    t_fifo_cmd  fifo_cmd;
    t_fifo_res  fifo_res;
    t_palettes  r_pal;
    logic       r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic       r_out_under;
    logic       out_free, adv, in_take;

    assign out_free = !r_out_valid || o_res.ready;
    assign adv      = r_in_valid && (!fifo_res.has_result || out_free);
    assign i_req.ready = !r_in_valid || adv;
    assign in_take  = i_req.valid && i_req.ready;

    always_comb begin
        fifo_cmd    = r_in;
        fifo_cmd.go = adv;
    end

    pfsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (fifo_cmd),
        .i_pal   (r_pal),
        .o_res   (fifo_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BG_PAL:   r_pal.bg   <= i_cfg_data;
                CFG_OBJ_PAL0: r_pal.obj0 <= i_cfg_data;
                CFG_OBJ_PAL1: r_pal.obj1 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (in_take) begin
            r_in.go             <= 1'b1;
            r_in.req_type       <= t_req_type'(i_req.req_type);
            r_in.plane_low      <= i_req.plane_low;
            r_in.plane_high     <= i_req.plane_high;
            r_in.mirror_x       <= i_req.mirror_x;
            r_in.palette_select <= i_req.palette_select;
            r_in.behind_bg      <= i_req.behind_bg;
            r_in.drop_count     <= i_req.drop_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && fifo_res.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && fifo_res.has_result) begin
            r_out_code  <= fifo_res.pixel_code;
            r_out_under <= fifo_res.underflow;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pixel_code = r_out_code;
    assign o_res.underflow  = r_out_under;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !(adv && fifo_res.has_result))
        else $error("stalled result overwritten");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("blocked request lost");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |-> !i_req.ready)
        else $error("request taken while register is blocked");
`endif

endmodule

`default_nettype wire
